[rtl/iuct_pkg.sv]
// ----------------------------------------------------------------------------
// iuct_pkg: shared definitions for the interval union coverage table
// Field widths and status codes used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package iuct_pkg;

  localparam int unsigned IN_W     = 32;  // width of range_first and range_last
  localparam int unsigned TOTAL_W  = 33;  // width of covered_total
  localparam int unsigned COUNT_W  = 7;   // width of range_count
  localparam int unsigned STATUS_W = 2;   // width of status

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REVERSED = 2'd2
  } status_t;

endpackage

`default_nettype wire

[rtl/iuct_if.sv]
// ----------------------------------------------------------------------------
// iuct_if: valid/ready channels of the interval union coverage table
// One channel carries ranges to add, the other carries the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface iuct_range_if;
  logic                       valid;
  logic                       ready;
  logic [iuct_pkg::IN_W-1:0]  range_first;
  logic [iuct_pkg::IN_W-1:0]  range_last;

  modport source (output valid, output range_first, output range_last, input ready);
  modport sink   (input valid, input range_first, input range_last, output ready);
endinterface

interface iuct_result_if;
  logic                          valid;
  logic                          ready;
  logic [iuct_pkg::TOTAL_W-1:0]  covered_total;
  logic [iuct_pkg::COUNT_W-1:0]  range_count;
  logic [iuct_pkg::STATUS_W-1:0] status;

  modport source (output valid, output covered_total, output range_count, output status,
                  input ready);
  modport sink   (input valid, input covered_total, input range_count, input status,
                  output ready);
endinterface

`default_nettype wire

[rtl/interval_union_coverage_table.sv]
// ----------------------------------------------------------------------------
// interval_union_coverage_table: sorted union of inclusive integer ranges
// Adds one range per item, merging it with every stored range that overlaps
// or touches it, and reports the covered total and the number of ranges.
// ----------------------------------------------------------------------------
// Usage:
//   ranges  (sink):   one item holds range_first and range_last.
//   results (source): one item per input with covered_total, range_count and
//                     status (accepted, rejected full, rejected reversed).
//   The table sits in a two-bank memory. An add streams the current bank
//   into the other one, reading each entry and then evaluating it,
//   through a single compare and add unit, then flips banks.
//   The read-then-evaluate loop over the memory port sets the time an add
//   takes, which grows with the number of stored ranges; a reversed range
//   goes straight to the output register without touching the table.
//   ranges.ready is high only while idle and rises with the edge that loads
//   the output register, so a new range is taken only after the result of
//   the last one is in that register.
//   The output register holds a finished item while results.ready is low;
//   the next item can be accepted meanwhile, and its result waits for the
//   register to free up.
//   Reset empties the table and clears the total; memory contents are left
//   as they are, since only entries below the range count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_union_coverage_table #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  iuct_range_if.sink           ranges,
  iuct_result_if.source        results
);

  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned CW1   = COORD_BITS + 1;
  localparam int unsigned TW    = iuct_pkg::TOTAL_W;

  typedef struct packed {
    logic [COORD_BITS-1:0] first;
    logic [COORD_BITS-1:0] last;
  } span_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_EVAL   = 6'b000100,
    S_PLACE  = 6'b001000,
    S_COMMIT = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_BELOW = 3'b001,
    PH_MERGE = 3'b010,
    PH_ABOVE = 3'b100
  } phase_t;

  state_t                 state;
  phase_t                 phase;
  logic                   bank;
  logic [CNT_W-1:0]       count;
  logic [TW-1:0]          covered;
  logic [COORD_BITS-1:0]  lo;
  logic [COORD_BITS-1:0]  hi;
  logic [CNT_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       wr_ptr;
  logic                   merged_any;
  logic [TW-1:0]          removed;
  iuct_pkg::status_t      status_r;
  span_t                  ent;

  logic                          out_valid;
  logic [TW-1:0]                 out_total;
  logic [iuct_pkg::COUNT_W-1:0]  out_count;
  iuct_pkg::status_t             out_status;

  // Two banks: the current table is read from bank, the new one is built in ~bank.
  span_t mem [2][MAX_RANGES];

  logic [COORD_BITS-1:0]  in_lo;
  logic [COORD_BITS-1:0]  in_hi;
  logic                   in_fire;
  logic                   below;
  logic                   touches;
  logic                   last_entry;
  logic                   reject_full;
  logic                   out_free;
  logic                   wr_en;
  span_t                  wr_data;
  logic [TW-1:0]          span_len;
  logic [TW-1:0]          new_len;

  assign in_lo    = COORD_BITS'(ranges.range_first);
  assign in_hi    = COORD_BITS'(ranges.range_last);
  assign in_fire  = ranges.valid && ranges.ready;
  assign out_free = !out_valid || results.ready;

  assign ranges.ready          = (state == S_IDLE);
  assign results.valid         = out_valid;
  assign results.covered_total = out_total;
  assign results.range_count   = out_count;
  assign results.status        = out_status;

  // Compares are done one bit wider so that last + 1 cannot wrap.
  assign below       = (CW1'(ent.last) + CW1'(1)) < CW1'(lo);
  assign touches     = CW1'(ent.first) <= (CW1'(hi) + CW1'(1));
  assign last_entry  = (rd_ptr + CNT_W'(1)) == count;
  assign reject_full = !merged_any && (count >= CNT_W'(MAX_RANGES));
  assign span_len    = TW'(CW1'(ent.last) - CW1'(ent.first) + CW1'(1));
  assign new_len     = TW'(CW1'(hi) - CW1'(lo) + CW1'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_data = ent;
    case (state)
      S_EVAL: begin
        wr_en = ((phase == PH_BELOW) && below) || (phase == PH_ABOVE);
      end
      S_PLACE: begin
        wr_en   = !reject_full;
        wr_data = '{first: lo, last: hi};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[~bank][wr_ptr[IDX_W-1:0]] <= wr_data;
    end
    if (state == S_READ) begin
      ent <= mem[bank][rd_ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_BELOW;
      bank      <= 1'b0;
      count     <= '0;
      covered   <= '0;
      out_valid <= 1'b0;
    end else begin
      // In S_OUT a taken item is replaced by the next one below.
      if (results.valid && results.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            lo         <= in_lo;
            hi         <= in_hi;
            rd_ptr     <= '0;
            wr_ptr     <= '0;
            merged_any <= 1'b0;
            removed    <= '0;
            phase      <= PH_BELOW;
            if (in_lo > in_hi) begin
              status_r <= iuct_pkg::ST_REVERSED;
              state    <= S_OUT;
            end else if (count == '0) begin
              state <= S_PLACE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          case (phase)
            PH_BELOW: begin
              if (below) begin
                wr_ptr <= wr_ptr + CNT_W'(1);
                rd_ptr <= rd_ptr + CNT_W'(1);
                state  <= last_entry ? S_PLACE : S_READ;
              end else begin
                // Same entry is evaluated again against the merge rule.
                phase <= PH_MERGE;
              end
            end
            PH_MERGE: begin
              if (touches) begin
                if (ent.first < lo) begin
                  lo <= ent.first;
                end
                if (ent.last > hi) begin
                  hi <= ent.last;
                end
                removed    <= removed + span_len;
                merged_any <= 1'b1;
                rd_ptr     <= rd_ptr + CNT_W'(1);
                state      <= last_entry ? S_PLACE : S_READ;
              end else begin
                // The held entry is written after the merged range.
                phase <= PH_ABOVE;
                state <= S_PLACE;
              end
            end
            PH_ABOVE: begin
              wr_ptr <= wr_ptr + CNT_W'(1);
              rd_ptr <= rd_ptr + CNT_W'(1);
              state  <= last_entry ? S_COMMIT : S_READ;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_PLACE: begin
          if (reject_full) begin
            status_r <= iuct_pkg::ST_FULL;
            state    <= S_OUT;
          end else begin
            status_r <= iuct_pkg::ST_ACCEPTED;
            wr_ptr   <= wr_ptr + CNT_W'(1);
            state    <= (phase == PH_ABOVE) ? S_EVAL : S_COMMIT;
          end
        end
        S_COMMIT: begin
          bank    <= ~bank;
          count   <= wr_ptr;
          covered <= covered - removed + new_len;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_total  <= covered;
            out_count  <= iuct_pkg::COUNT_W'(count);
            out_status <= status_r;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("stored range count exceeds table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> wr_ptr < CNT_W'(MAX_RANGES))
    else $error("table write beyond last entry");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> rd_ptr < count)
    else $error("table read beyond stored ranges");

  a_full_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE) && reject_full |=>
      (state == S_OUT) && (count == $past(count)) && (bank == $past(bank)))
    else $error("rejected add changed the table");

  a_commit_grows_by_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> wr_ptr <= count + CNT_W'(1))
    else $error("one add produced more than one new range");

endmodule

`default_nettype wire
